// ===== rtl/core/si_pkg.sv =====
package si_pkg;

   // Coordinate width; positions on the ports stay 32 bits wide.
   localparam int COORD_BITS = 32;
   localparam int FRAME_BITS = 32;
   localparam int PORT_BITS  = 32;
   localparam int CNT_BITS   = $clog2(COORD_BITS);

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-1:0]        mag_type;
   typedef logic [FRAME_BITS-1:0]        frame_type;

   typedef enum logic [1:0] {
      QK_NONE,
      QK_HOLD,
      QK_INTERP
   } qry_kind_type;

   // Query classification handed from the slot store to the control.
   typedef struct packed {
      qry_kind_type kind;
      frame_type    frame;
      coord_type    x;
      coord_type    y;
      coord_type    ax;
      coord_type    bx;
      coord_type    ay;
      coord_type    by;
      frame_type    num;
      frame_type    den;
   } qry_type;

   typedef enum logic [1:0] {
      LP_IDLE,
      LP_MUL,
      LP_DIV,
      LP_RND
   } lane_phase_type;

   typedef struct packed {
      logic      done;
      coord_type value;
   } lane_res_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_CALC,
      CS_HOLD
   } ctl_state_type;

   // Take the low COORD_BITS bits of a port value as a signed coordinate.
   function automatic coord_type coord_in(logic [PORT_BITS-1:0] raw);
      logic [63:0] wide;
      wide = 64'(raw);
      return wide[COORD_BITS-1:0];
   endfunction

   // Place the coordinate bits on a port, zero above COORD_BITS.
   function automatic logic [PORT_BITS-1:0] coord_out(coord_type v);
      logic [63:0] wide;
      wide = '0;
      wide[COORD_BITS-1:0] = v;
      return wide[PORT_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/si_slots.sv =====
module si_slots import si_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type frame,
   input  coord_type pos_x,
   input  coord_type pos_y,
   output qry_type   qry
);

   logic      early_valid_ff, early_valid_in;
   logic      late_valid_ff, late_valid_in;
   frame_type early_frame_ff, early_frame_in;
   frame_type late_frame_ff, late_frame_in;
   coord_type early_x_ff, early_x_in;
   coord_type early_y_ff, early_y_in;
   coord_type late_x_ff, late_x_in;
   coord_type late_y_ff, late_y_in;

   always_comb begin
      early_valid_in = early_valid_ff;
      late_valid_in  = late_valid_ff;
      early_frame_in = early_frame_ff;
      late_frame_in  = late_frame_ff;
      early_x_in     = early_x_ff;
      early_y_in     = early_y_ff;
      late_x_in      = late_x_ff;
      late_y_in      = late_y_ff;
      if (push) begin
         if (!early_valid_ff && !late_valid_ff) begin
            early_valid_in = 1'b1;
            early_frame_in = frame;
            early_x_in     = pos_x;
            early_y_in     = pos_y;
         end else if (early_valid_ff && !late_valid_ff) begin
            if (frame > early_frame_ff) begin
               late_valid_in = 1'b1;
               late_frame_in = frame;
               late_x_in     = pos_x;
               late_y_in     = pos_y;
            end
         end else if (early_valid_ff && late_valid_ff) begin
            if (frame > late_frame_ff) begin
               // slide the window
               early_frame_in = late_frame_ff;
               early_x_in     = late_x_ff;
               early_y_in     = late_y_ff;
               late_frame_in  = frame;
               late_x_in      = pos_x;
               late_y_in      = pos_y;
            end else if (frame > early_frame_ff) begin
               late_frame_in = frame;
               late_x_in     = pos_x;
               late_y_in     = pos_y;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         early_valid_ff <= 1'b0;
         late_valid_ff  <= 1'b0;
      end else begin
         early_valid_ff <= early_valid_in;
         late_valid_ff  <= late_valid_in;
      end
      early_frame_ff <= early_frame_in;
      late_frame_ff  <= late_frame_in;
      early_x_ff     <= early_x_in;
      early_y_ff     <= early_y_in;
      late_x_ff      <= late_x_in;
      late_y_ff      <= late_y_in;
   end

   always_comb begin
      qry.ax  = early_x_ff;
      qry.bx  = late_x_ff;
      qry.ay  = early_y_ff;
      qry.by  = late_y_ff;
      qry.num = frame - early_frame_ff;
      qry.den = late_frame_ff - early_frame_ff;
      if (!early_valid_ff || !late_valid_ff || frame < early_frame_ff) begin
         qry.kind  = QK_NONE;
         qry.frame = '0;
         qry.x     = '0;
         qry.y     = '0;
      end else if (early_frame_ff == late_frame_ff) begin
         qry.kind  = QK_HOLD;
         qry.frame = early_frame_ff;
         qry.x     = early_x_ff;
         qry.y     = early_y_ff;
      end else if (frame > late_frame_ff) begin
         qry.kind  = QK_HOLD;
         qry.frame = late_frame_ff;
         qry.x     = late_x_ff;
         qry.y     = late_y_ff;
      end else begin
         qry.kind  = QK_INTERP;
         qry.frame = frame;
         qry.x     = '0;
         qry.y     = '0;
      end
   end

endmodule

// ===== rtl/core/si_lane.sv =====
module si_lane import si_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  coord_type    a,
   input  coord_type    b,
   input  frame_type    num,
   input  frame_type    den,
   output lane_res_type res
);

   lane_phase_type            phase_ff, phase_in;
   logic                      done_ff, done_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   coord_type                 a_ff, a_in;
   mag_type                   mag_ff, mag_in;
   frame_type                 num_ff, num_in;
   frame_type                 den_ff, den_in;
   frame_type                 rem_ff, rem_in;
   mag_type                   quo_ff, quo_in;
   coord_type                 value_ff, value_in;

   logic [COORD_BITS:0]            diff;
   logic [COORD_BITS:0]            diff_neg;
   logic [COORD_BITS+FRAME_BITS-1:0] prod;
   logic [FRAME_BITS:0]            trial;
   logic [FRAME_BITS:0]            trial_sub;
   logic                           trial_ge;
   logic                           round_up;
   logic [COORD_BITS:0]            q_sum;
   logic [COORD_BITS:0]            a_ext;
   logic [COORD_BITS:0]            sum;

   always_comb begin
      diff      = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
      diff_neg  = -diff;
      prod      = (COORD_BITS+FRAME_BITS)'(mag_ff) * (COORD_BITS+FRAME_BITS)'(num_ff);
      trial     = {rem_ff, quo_ff[COORD_BITS-1]};
      trial_sub = trial - {1'b0, den_ff};
      trial_ge  = trial >= {1'b0, den_ff};
      round_up  = {rem_ff, 1'b0} >= {1'b0, den_ff};
      q_sum     = {1'b0, quo_ff} + (COORD_BITS+1)'(round_up);
      a_ext     = {a_ff[COORD_BITS-1], a_ff};
      sum       = neg_ff ? a_ext - q_sum : a_ext + q_sum;

      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      a_in     = a_ff;
      mag_in   = mag_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      value_in = value_ff;

      unique case (phase_ff)
         LP_IDLE: begin
            if (start) begin
               a_in     = a;
               neg_in   = diff[COORD_BITS];
               mag_in   = diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0]
                                           : diff[COORD_BITS-1:0];
               num_in   = num;
               den_in   = den;
               phase_in = LP_MUL;
            end
         end
         LP_MUL: begin
            // high part is already below den since num <= den
            rem_in   = prod[COORD_BITS+FRAME_BITS-1:COORD_BITS];
            quo_in   = prod[COORD_BITS-1:0];
            cnt_in   = '0;
            phase_in = LP_DIV;
         end
         LP_DIV: begin
            rem_in = trial_ge ? trial_sub[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
            quo_in = {quo_ff[COORD_BITS-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(COORD_BITS-1)) begin
               phase_in = LP_RND;
            end
         end
         LP_RND: begin
            value_in = sum[COORD_BITS-1:0];
            done_in  = 1'b1;
            phase_in = LP_IDLE;
         end
         default: begin
            phase_in = LP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= LP_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      neg_ff   <= neg_in;
      a_ff     <= a_in;
      mag_ff   <= mag_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      value_ff <= value_in;
   end

   assign res.done  = done_ff;
   assign res.value = value_ff;

endmodule

// ===== rtl/core/snapshot_interpolator.sv =====
// Snapshot interpolator: holds an earlier and a later timestamped position
// snapshot and answers render queries from them. A push item (tuser opcode
// bit low) with its valid flag set fills the empty slots, slides the window
// when its frame is newer than the later snapshot, or replaces the later one
// when its frame lies between the two; any other push is dropped, and no push
// gives a result item. A query item (opcode bit high) gives exactly one
// result item: invalid with zero fields when a slot is empty or the query
// frame precedes the earlier frame, the earlier snapshot when both frames are
// equal, the later snapshot when the query is past it, and otherwise x and y
// interpolated linearly as a + round((b - a) * n / d) with exact rounding,
// half away from zero. Frames compare as unsigned values, no wraparound.
// Timing: a query that needs no interpolation passes from the staging
// register to the output register, and the next item can enter once it sits
// there. An interpolated query first passes through the multiply, divide and
// round steps of the two coordinate lanes before it is staged. The bit-serial
// restoring divider in each lane retires one quotient bit per cycle after the
// multiply step. A query that finds the output register still full waits in
// the staging register until it drains. The block takes one query at a time
// and is ready again once the result sits in the output register, so a
// waiting result does not stall pushes that follow it.
module snapshot_interpolator import si_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // frame[31:0], pos_x[63:32], pos_y[95:64]
   input  logic [1:0]  req_tuser,   // opcode[0], snapshot_valid[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // out_frame[31:0], out_x[63:32], out_y[95:64]
   output logic        rsp_tuser    // out_valid[0]
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   frame_type     rsp_frame_ff, rsp_frame_in;
   coord_type     rsp_x_ff, rsp_x_in;
   coord_type     rsp_y_ff, rsp_y_in;
   logic          res_ok_ff, res_ok_in;
   frame_type     res_frame_ff, res_frame_in;
   coord_type     res_x_ff, res_x_in;
   coord_type     res_y_ff, res_y_in;

   logic          accept;
   logic          push;
   logic          query;
   logic          lane_start;
   logic          out_free;
   frame_type     req_frame;
   coord_type     req_x;
   coord_type     req_y;
   qry_type       qry;
   lane_res_type  lane_x_res;
   lane_res_type  lane_y_res;

   // Unpack the request item.
   assign req_frame = req_tdata[31:0];
   assign req_x     = coord_in(req_tdata[63:32]);
   assign req_y     = coord_in(req_tdata[95:64]);

   assign req_tready = (state_ff == CS_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (req_tuser[0] == OP_PUSH) && req_tuser[1];
   assign query      = accept && (req_tuser[0] == OP_QUERY);
   assign lane_start = query && (qry.kind == QK_INTERP);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   si_slots u_slots (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .frame (req_frame),
      .pos_x (req_x),
      .pos_y (req_y),
      .qry   (qry)
   );

   // One lane per coordinate; both run in lockstep on the same n and d.
   si_lane u_lane_x (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .a     (qry.ax),
      .b     (qry.bx),
      .num   (qry.num),
      .den   (qry.den),
      .res   (lane_x_res)
   );

   si_lane u_lane_y (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .a     (qry.ay),
      .b     (qry.by),
      .num   (qry.num),
      .den   (qry.den),
      .res   (lane_y_res)
   );

   // Control: stage the query result, merge the lane outputs, then hand the
   // item to the output register once it is free.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      res_ok_in    = res_ok_ff;
      res_frame_in = res_frame_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;

      unique case (state_ff)
         CS_IDLE: begin
            if (query) begin
               res_ok_in    = (qry.kind != QK_NONE);
               res_frame_in = qry.frame;
               res_x_in     = qry.x;
               res_y_in     = qry.y;
               state_in     = (qry.kind == QK_INTERP) ? CS_CALC : CS_HOLD;
            end
         end
         CS_CALC: begin
            if (lane_x_res.done) begin
               res_x_in = lane_x_res.value;
               res_y_in = lane_y_res.value;
               state_in = CS_HOLD;
            end
         end
         CS_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_frame_in = res_frame_ff;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff    <= rsp_ok_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      res_ok_ff    <= res_ok_in;
      res_frame_ff <= res_frame_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {coord_out(rsp_y_ff), coord_out(rsp_x_ff), rsp_frame_ff};

`ifndef ASSERT_OFF
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      lane_x_res.done == lane_y_res.done)
      else $error("coordinate lanes finished out of step");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      lane_x_res.done |-> state_ff == CS_CALC)
      else $error("lane result arrived outside of a calculation");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == OP_QUERY) |=> state_ff != CS_IDLE)
      else $error("accepted query did not leave idle");

   a_hold_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_HOLD && (!rsp_tvalid || rsp_tready)) |=>
         (rsp_tvalid && state_ff == CS_IDLE))
      else $error("staged result not moved to the output register");
`endif

endmodule
